// ===== hdl/psw_pkg.sv =====
// Shared types and constants of the periodic slot wheel.
package psw_pkg;

  localparam int unsigned RES_W     = 6;
  localparam int unsigned UE_W      = 16;
  localparam int unsigned PER_W     = 12;
  localparam int unsigned SLOT_W    = 18;
  localparam int unsigned BKT_W     = 13;   // offset plus period, before the range check
  localparam int unsigned MOD_W     = 36;   // slot shifted against the wheel size
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned MAX_RES   = 16;   // results per consume

  localparam logic [1:0] REQ_ADD     = 2'd0;
  localparam logic [1:0] REQ_REMOVE  = 2'd1;
  localparam logic [1:0] REQ_CONSUME = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [UE_W-1:0]   ue_id;
    logic [RES_W-1:0]  resource_id;
    logic [PER_W-1:0]  period_slots;
    logic [PER_W-1:0]  first_offset;
    logic [SLOT_W-1:0] slot_number;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             entry_valid;
    logic [UE_W-1:0]  out_ue_id;
    logic [RES_W-1:0] out_resource_id;
    logic             last;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLR,
    OP_LOAD,
    OP_MOD_STEP,
    OP_MOD_DONE,
    OP_CNT_RD,
    OP_CNT_LATCH,
    OP_ENT_RD,
    OP_LAST_RD,
    OP_ADD_WR,
    OP_MOVE_WR,
    OP_INC_I,
    OP_NEXT_B,
    OP_FLAG,
    OP_EMIT_STAT,
    OP_EMIT_ENT
  } dp_op_e;

  typedef struct packed {
    logic [1:0] req;
    logic       clr_done;
    logic       mod_done;
    logic       b_in;
    logic       i_eq_n;
    logic       n_full;
    logic       n_zero;
    logic       hit;
    logic       c_last;
    logic       out_free;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_MOD,
    S_MODFIN,
    S_BKT,
    S_CNT,
    S_ENT,
    S_CMP,
    S_MOVE,
    S_NEXT,
    S_RESP,
    S_CSTART,
    S_CEM
  } state_e;

endpackage

// ===== hdl/psw_ctrl.sv =====
// Sequencer of the periodic slot wheel.
module psw_ctrl import psw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_op_e   op_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_o       = OP_NOP;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_CLEAR: begin
        op_o = OP_CLR;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.req)
          REQ_ADD, REQ_REMOVE: state_d = S_BKT;
          REQ_CONSUME:         state_d = S_MOD;
          default:             state_d = S_IDLE;
        endcase
      end
      S_MOD: begin
        op_o = OP_MOD_STEP;
        if (stat_i.mod_done) state_d = S_MODFIN;
      end
      S_MODFIN: begin
        op_o    = OP_MOD_DONE;
        state_d = S_BKT;
      end
      S_BKT: begin
        if (stat_i.b_in) begin
          op_o    = OP_CNT_RD;
          state_d = S_CNT;
        end else begin
          state_d = S_RESP;
        end
      end
      S_CNT: begin
        op_o    = OP_CNT_LATCH;
        state_d = (stat_i.req == REQ_CONSUME) ? S_CSTART : S_ENT;
      end
      S_ENT: begin
        if (stat_i.i_eq_n) begin
          // not in bucket: add appends unless full, remove flags it missing
          op_o    = (stat_i.req == REQ_ADD && !stat_i.n_full) ? OP_ADD_WR : OP_FLAG;
          state_d = S_NEXT;
        end else begin
          op_o    = OP_ENT_RD;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (stat_i.hit) begin
          if (stat_i.req == REQ_ADD) begin
            op_o    = OP_FLAG;
            state_d = S_NEXT;
          end else begin
            op_o    = OP_LAST_RD;
            state_d = S_MOVE;
          end
        end else begin
          op_o    = OP_INC_I;
          state_d = S_ENT;
        end
      end
      S_MOVE: begin
        op_o    = OP_MOVE_WR;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        op_o    = OP_NEXT_B;
        state_d = S_BKT;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          op_o    = OP_EMIT_STAT;
          state_d = S_IDLE;
        end
      end
      S_CSTART: begin
        if (stat_i.n_zero) begin
          if (stat_i.out_free) begin
            op_o    = OP_EMIT_STAT;
            state_d = S_IDLE;
          end
        end else begin
          op_o    = OP_ENT_RD;
          state_d = S_CEM;
        end
      end
      S_CEM: begin
        if (stat_i.out_free) begin
          op_o    = OP_EMIT_ENT;
          state_d = stat_i.c_last ? S_IDLE : S_CSTART;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/psw_dp.sv =====
// Datapath of the periodic slot wheel: bucket stores, walk registers, output register.
module psw_dp import psw_pkg::*; #(
  parameter int unsigned NUM_SLOTS    = 2560,
  parameter int unsigned BUCKET_DEPTH = 16,
  parameter int unsigned ID_BITS      = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  req_t     req_i,
  input  dp_op_e   op_i,
  output dp_stat_t stat_o,
  input  logic     out_stall_i,
  output logic     out_valid_o,
  output rsp_t     out_data_o
);

  localparam int unsigned BW  = $clog2(NUM_SLOTS);
  localparam int unsigned CW  = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned EAW = $clog2(NUM_SLOTS * BUCKET_DEPTH);
  localparam int unsigned KW  = ID_BITS + RES_W;
  localparam int unsigned NE  = NUM_SLOTS * BUCKET_DEPTH;
  localparam logic [EAW-1:0] DEPTH_E = EAW'(BUCKET_DEPTH);

  logic [CW-1:0]  cnt_mem [NUM_SLOTS];
  logic [KW-1:0]  ent_mem [NE];

  logic [1:0]        req_q;
  logic [KW-1:0]     key_q;
  logic [BKT_W-1:0]  per_q, b_q;
  logic [MOD_W-1:0]  rem_q;
  logic [STEP_W-1:0] k_q;
  logic [CW-1:0]     n_q, i_q, cnt_rd_q;
  logic [KW-1:0]     ent_rd_q;
  logic              dup_q, full_q, miss_q;
  logic [BW-1:0]     clr_q;
  logic              out_vld_q;
  rsp_t              out_q;

  logic [MOD_W-1:0] sub;
  logic [BW-1:0]    bidx;
  logic [EAW-1:0]   base;
  logic [7:0]       i_nxt;
  logic             out_free;

  assign sub      = MOD_W'(NUM_SLOTS) << k_q;
  assign bidx     = b_q[BW-1:0];
  assign base     = EAW'(bidx) * DEPTH_E;
  assign i_nxt    = 8'(i_q) + 8'd1;
  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    stat_o.req      = req_q;
    stat_o.clr_done = (clr_q == BW'(NUM_SLOTS - 1));
    stat_o.mod_done = (k_q == '0);
    stat_o.b_in     = (b_q < BKT_W'(NUM_SLOTS));
    stat_o.i_eq_n   = (i_q == n_q);
    stat_o.n_full   = (n_q >= CW'(BUCKET_DEPTH));
    stat_o.n_zero   = (n_q == '0);
    stat_o.hit      = (ent_rd_q == key_q);
    stat_o.c_last   = (i_nxt == 8'(n_q)) || (i_nxt == 8'(MAX_RES));
    stat_o.out_free = out_free;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (op_i == OP_CLR) clr_q <= clr_q + BW'(1);
      if (op_i == OP_EMIT_STAT || op_i == OP_EMIT_ENT) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        req_q  <= req_i.req_type;
        key_q  <= {req_i.ue_id[ID_BITS-1:0], req_i.resource_id};
        per_q  <= (req_i.period_slots == '0) ? BKT_W'(NUM_SLOTS)
                                              : BKT_W'(req_i.period_slots);
        b_q    <= BKT_W'(req_i.first_offset);
        rem_q  <= MOD_W'(req_i.slot_number);
        k_q    <= STEP_W'(SLOT_W);
        dup_q  <= 1'b0;
        full_q <= 1'b0;
        miss_q <= 1'b0;
      end
      OP_MOD_STEP: begin
        // restoring reduction, one shifted wheel size per cycle
        if (rem_q >= sub) rem_q <= rem_q - sub;
        k_q <= k_q - STEP_W'(1);
      end
      OP_MOD_DONE: begin
        if (rem_q >= MOD_W'(NUM_SLOTS)) begin
          b_q <= BKT_W'(rem_q - MOD_W'(NUM_SLOTS));
        end else begin
          b_q <= BKT_W'(rem_q);
        end
      end
      OP_CNT_RD:    cnt_rd_q <= cnt_mem[bidx];
      OP_CNT_LATCH: begin
        n_q <= cnt_rd_q;
        i_q <= '0;
      end
      OP_ENT_RD:  ent_rd_q <= ent_mem[base + EAW'(i_q)];
      OP_LAST_RD: ent_rd_q <= ent_mem[base + EAW'(n_q - CW'(1))];
      OP_INC_I:   i_q <= i_q + CW'(1);
      OP_NEXT_B:  b_q <= b_q + per_q;
      OP_FLAG: begin
        case (req_q)
          REQ_ADD: begin
            if (stat_o.hit && !stat_o.i_eq_n) dup_q <= 1'b1;
            else full_q <= 1'b1;
          end
          default: miss_q <= 1'b1;
        endcase
      end
      OP_EMIT_STAT: begin
        out_q.entry_valid     <= 1'b0;
        out_q.out_ue_id       <= '0;
        out_q.out_resource_id <= '0;
        out_q.last            <= 1'b1;
        case (req_q)
          REQ_ADD:    out_q.status <= full_q ? ST_FULL : (dup_q ? ST_DUP : ST_OK);
          REQ_REMOVE: out_q.status <= miss_q ? ST_MISSING : ST_OK;
          default:    out_q.status <= ST_OK;
        endcase
      end
      OP_EMIT_ENT: begin
        out_q.status          <= ST_OK;
        out_q.entry_valid     <= 1'b1;
        out_q.out_ue_id       <= UE_W'(ent_rd_q[KW-1:RES_W]);
        out_q.out_resource_id <= ent_rd_q[RES_W-1:0];
        out_q.last            <= stat_o.c_last;
        i_q                   <= i_q + CW'(1);
      end
      default: ;
    endcase
  end

  // bucket stores
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_CLR:     cnt_mem[clr_q] <= '0;
      OP_ADD_WR:  cnt_mem[bidx]  <= n_q + CW'(1);
      OP_MOVE_WR: cnt_mem[bidx]  <= n_q - CW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_ADD_WR:  ent_mem[base + EAW'(n_q)] <= key_q;
      OP_MOVE_WR: ent_mem[base + EAW'(i_q)] <= ent_rd_q;
      default: ;
    endcase
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/periodic_slot_wheel.sv =====
// Top level of the periodic slot wheel.
//
//  channel  dir  signals                          payload
//  request  in   in_valid_i / in_stall_o          req_t
//  result   out  out_valid_o / out_stall_i        rsp_t
//
// After reset a clearing pass writes every bucket count, with in_stall_o high
// throughout.
// Add/remove: accept and dispatch, then walk every bucket touched, reading its
// count and entries through the single-port entry store, then end the walk and
// give the status.
// Consume: accept and dispatch, reduce the slot number modulo NUM_SLOTS, read
// the count, then emit up to MAX_RES entries (a status result for an empty bucket).
// One request at a time; output stalls hold the sequencer in place.
module periodic_slot_wheel import psw_pkg::*; #(
  parameter int unsigned NUM_SLOTS    = 2560,
  parameter int unsigned BUCKET_DEPTH = 16,
  parameter int unsigned ID_BITS      = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  dp_op_e   op;
  dp_stat_t stat;

  psw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .op_o       (op)
  );

  psw_dp #(
    .NUM_SLOTS    (NUM_SLOTS),
    .BUCKET_DEPTH (BUCKET_DEPTH),
    .ID_BITS      (ID_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_data_i),
    .op_i        (op),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
